@@ design/ipv4hv_pkg.sv @@
// Shared types, codes and helpers of the IPv4 header validate filter.
package ipv4hv_pkg;

    // Verdict codes carried on the result channel
    typedef enum logic [2:0] {
        VERDICT_ACCEPT      = 3'd0,
        VERDICT_BAD_VERSION = 3'd1,
        VERDICT_SHORT_HDR   = 3'd2,
        VERDICT_TTL_ZERO    = 3'd3,
        VERDICT_BAD_CSUM    = 3'd4,
        VERDICT_FROM_SELF   = 3'd5,
        VERDICT_NOT_FOR_US  = 3'd6,
        VERDICT_OTHER_PROTO = 3'd7
    } verdict_t;

    // Register indexes on the configuration port (word address)
    typedef enum logic {
        REG_OWN_ADDRESS       = 1'b0,
        REG_ACCEPTED_PROTOCOL = 1'b1
    } reg_index_t;

    localparam int unsigned PADDR_WIDTH = 3;

    localparam logic [3:0]  IPV4_VERSION        = 4'd4;
    localparam logic [3:0]  MIN_IHL_WORDS       = 4'd5;
    localparam logic [15:0] CSUM_GOOD           = 16'hFFFF;
    localparam logic [31:0] OWN_ADDRESS_RESET   = 32'd0;
    localparam logic [7:0]  ACCEPTED_PROTO_RESET = 8'd6;

    // Ones-complement add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] word);
        logic [16:0] raw;
        begin
            raw = {1'b0, acc} + {1'b0, word};
            return raw[15:0] + {15'd0, raw[16]};
        end
    endfunction

endpackage

@@ design/ipv4hv_if.sv @@
// Stream channel interfaces of the IPv4 header validate filter.
interface ipv4hv_pkt_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface ipv4hv_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [5:0]  header_bytes;
    logic [15:0] total_length;
    logic [31:0] source_address;

    modport source (output valid, output verdict, output header_bytes, output total_length,
                    output source_address, input ready);
    modport sink (input valid, input verdict, input header_bytes, input total_length,
                  input source_address, output ready);
endinterface

@@ design/ipv4_header_validate_filter.sv @@
// Top level of the IPv4 header validate filter: capture, checksum and verdict.
//
//  channel  | role   | payload                                        | transfer
//  ---------+--------+------------------------------------------------+-----------------
//  pkt      | sink   | data_byte[7:0], first_byte                     | valid && ready
//  res      | source | verdict[2:0], header_bytes[5:0],               | valid && ready
//           |        | total_length[15:0], source_address[31:0]       |
//  apb      | slave  | own_address (0x0), accepted_protocol (0x4)     | psel&&penable&&pwrite
//
//  Flow: one byte per cycle while res is not stalled; a verdict passes the input
//  register, then the result register, after the transfer of the byte that causes it.
//  Reset: rst_n clears the packet state to idle and loads the register defaults.
//  Stalls: a held result blocks the processing stage only; pkt.ready drops only
//  while both the input register and the result register are full and res is stalled.
module ipv4_header_validate_filter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    ipv4hv_pkt_if.sink                           pkt,
    ipv4hv_res_if.source                         res,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ipv4hv_pkg::PADDR_WIDTH-1:0]   paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] own_addr_reg;
    logic [7:0]  accept_proto_reg;
    logic        cfg_write;
    ipv4hv_pkg::reg_index_t cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = ipv4hv_pkg::reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg     <= ipv4hv_pkg::OWN_ADDRESS_RESET;
            accept_proto_reg <= ipv4hv_pkg::ACCEPTED_PROTO_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                ipv4hv_pkg::REG_OWN_ADDRESS:       own_addr_reg     <= pwdata;
                ipv4hv_pkg::REG_ACCEPTED_PROTOCOL: accept_proto_reg <= pwdata[7:0];
                default:                           ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (cfg_sel)
            ipv4hv_pkg::REG_OWN_ADDRESS:       prdata = own_addr_reg;
            ipv4hv_pkg::REG_ACCEPTED_PROTOCOL: prdata = {24'd0, accept_proto_reg};
            default:                           prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register: one byte waiting for the processing stage
    // ------------------------------------------------------------------
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;
    logic       advance;     // processing stage may consume the held byte
    logic       pkt_xfer;

    logic       res_valid_reg, res_valid_next;

    // The result register frees up when empty or when its transfer completes
    assign advance  = !res_valid_reg || res.ready;
    assign pkt.ready = !in_valid_reg || advance;
    assign pkt_xfer  = pkt.valid && pkt.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (pkt_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (pkt_xfer)
        begin
            in_byte_reg  <= pkt.data_byte;
            in_first_reg <= pkt.first_byte;
        end
    end

    // ------------------------------------------------------------------
    // Packet state
    // ------------------------------------------------------------------
    logic [5:0]  pos_reg,   pos_next;     // next header byte position
    logic        in_hdr_reg, in_hdr_next; // header in progress
    logic [15:0] sum_reg,   sum_next;     // running ones-complement sum
    logic [7:0]  pend_reg,  pend_next;    // high byte of the word being built
    logic [7:0]  vl_reg,    vl_next;      // version / IHL byte
    logic [7:0]  ttl_reg,   ttl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] tlen_reg,  tlen_next;
    logic [31:0] src_reg,   src_next;
    logic [31:0] dst_reg,   dst_next;

    logic                  emit;
    ipv4hv_pkg::verdict_t  verdict_new;
    logic [5:0]            hdr_bytes_cur;

    assign hdr_bytes_cur = {vl_reg[3:0], 2'b00};

    always_comb
    begin
        pos_next    = pos_reg;
        in_hdr_next = in_hdr_reg;
        sum_next    = sum_reg;
        pend_next   = pend_reg;
        vl_next     = vl_reg;
        ttl_next    = ttl_reg;
        proto_next  = proto_reg;
        tlen_next   = tlen_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        emit        = 1'b0;
        verdict_new = ipv4hv_pkg::VERDICT_ACCEPT;

        if (in_valid_reg && advance)
        begin
            if (in_first_reg)
            begin
                // Start afresh; any header in progress is dropped without a verdict
                pos_next    = 6'd0;
                in_hdr_next = 1'b0;
                sum_next    = 16'd0;
                pend_next   = 8'd0;
                vl_next     = in_byte_reg;
                ttl_next    = 8'd0;
                proto_next  = 8'd0;
                tlen_next   = 16'd0;
                src_next    = 32'd0;
                dst_next    = 32'd0;
                if (in_byte_reg[7:4] != ipv4hv_pkg::IPV4_VERSION)
                begin
                    emit        = 1'b1;
                    verdict_new = ipv4hv_pkg::VERDICT_BAD_VERSION;
                end
                else if (in_byte_reg[3:0] < ipv4hv_pkg::MIN_IHL_WORDS)
                begin
                    emit        = 1'b1;
                    verdict_new = ipv4hv_pkg::VERDICT_SHORT_HDR;
                end
                else
                begin
                    in_hdr_next = 1'b1;
                    pend_next   = in_byte_reg;
                    pos_next    = 6'd1;
                end
            end
            else if (in_hdr_reg)
            begin
                // Even positions open a word, odd ones close it into the sum
                if (!pos_reg[0])
                begin
                    pend_next = in_byte_reg;
                end
                else
                begin
                    sum_next = ipv4hv_pkg::ones_add(sum_reg, {pend_reg, in_byte_reg});
                end

                priority if (pos_reg == 6'd2 || pos_reg == 6'd3)
                begin
                    tlen_next = {tlen_reg[7:0], in_byte_reg};
                end
                else if (pos_reg == 6'd8)
                begin
                    ttl_next = in_byte_reg;
                end
                else if (pos_reg == 6'd9)
                begin
                    proto_next = in_byte_reg;
                end
                else if (pos_reg >= 6'd12 && pos_reg <= 6'd15)
                begin
                    src_next = {src_reg[23:0], in_byte_reg};
                end
                else if (pos_reg >= 6'd16 && pos_reg <= 6'd19)
                begin
                    dst_next = {dst_reg[23:0], in_byte_reg};
                end
                else
                begin
                    // service, identification, fragment, checksum and option bytes only feed the sum
                end

                pos_next = pos_reg + 6'd1;

                // Last byte of the declared header: decide in priority order
                if (pos_next == hdr_bytes_cur)
                begin
                    in_hdr_next = 1'b0;
                    emit        = 1'b1;
                    priority if (ttl_next == 8'd0)
                        verdict_new = ipv4hv_pkg::VERDICT_TTL_ZERO;
                    else if (sum_next != ipv4hv_pkg::CSUM_GOOD)
                        verdict_new = ipv4hv_pkg::VERDICT_BAD_CSUM;
                    else if (src_next == own_addr_reg)
                        verdict_new = ipv4hv_pkg::VERDICT_FROM_SELF;
                    else if (dst_next != own_addr_reg)
                        verdict_new = ipv4hv_pkg::VERDICT_NOT_FOR_US;
                    else if (proto_next != accept_proto_reg)
                        verdict_new = ipv4hv_pkg::VERDICT_OTHER_PROTO;
                    else
                        verdict_new = ipv4hv_pkg::VERDICT_ACCEPT;
                end
            end
            else
            begin
                // payload or stray byte while idle: drop
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 6'd0;
            in_hdr_reg <= 1'b0;
            sum_reg   <= 16'd0;
            pend_reg  <= 8'd0;
            vl_reg    <= 8'd0;
            ttl_reg   <= 8'd0;
            proto_reg <= 8'd0;
            tlen_reg  <= 16'd0;
            src_reg   <= 32'd0;
            dst_reg   <= 32'd0;
        end
        else
        begin
            pos_reg   <= pos_next;
            in_hdr_reg <= in_hdr_next;
            sum_reg   <= sum_next;
            pend_reg  <= pend_next;
            vl_reg    <= vl_next;
            ttl_reg   <= ttl_next;
            proto_reg <= proto_next;
            tlen_reg  <= tlen_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    ipv4hv_pkg::verdict_t res_verdict_reg;
    logic [5:0]           res_hdr_bytes_reg;
    logic [15:0]          res_tlen_reg;
    logic [31:0]          res_src_reg;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_verdict_reg   <= verdict_new;
            res_hdr_bytes_reg <= {vl_next[3:0], 2'b00};
            res_tlen_reg      <= tlen_next;
            res_src_reg       <= src_next;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.verdict        = res_verdict_reg;
    assign res.header_bytes   = res_hdr_bytes_reg;
    assign res.total_length   = res_tlen_reg;
    assign res.source_address = res_src_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A header in progress always has a valid version/IHL and sits inside it
    a_hdr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        in_hdr_reg |-> (vl_reg[7:4] == ipv4hv_pkg::IPV4_VERSION)
                    && (vl_reg[3:0] >= ipv4hv_pkg::MIN_IHL_WORDS)
                    && (pos_reg != 6'd0) && (pos_reg < hdr_bytes_cur))
        else $error("header position outside the declared header");

    // Input backpressure only comes from a stalled, full result register
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !pkt.ready |-> in_valid_reg && res_valid_reg && !res.ready)
        else $error("pkt.ready low without a stalled result");

    // Early verdicts carry no captured length or source
    a_early_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (res_verdict_reg == ipv4hv_pkg::VERDICT_BAD_VERSION
                       || res_verdict_reg == ipv4hv_pkg::VERDICT_SHORT_HDR)
        |-> (res_tlen_reg == 16'd0) && (res_src_reg == 32'd0))
        else $error("early verdict with captured fields");

    // A late verdict ends the header in progress
    a_verdict_ends_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        emit && !in_first_reg |=> !in_hdr_reg)
        else $error("header still open after its verdict");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the IPv4 header validate filter.
`timescale 1ns / 100ps

module tb_top;

    // Run limits and timing
    localparam int CYCLE_LIMIT = 400_000;
    localparam int LONG_HOLD   = 300;  // receiver hold-off used to back up the block
    localparam int SETTLE_GAP  = 8;    // a verdict passes the input and result registers; allow margin

    // Addresses used by the directed packets
    localparam logic [31:0] DIR_OWN = 32'hC0A8_0001;
    localparam logic [31:0] PEER    = 32'h0A00_0002;

    // One verdict as it leaves the block
    typedef struct packed {
        ipv4hv_pkg::verdict_t verdict;
        logic [5:0]  header_bytes;
        logic [15:0] total_length;
        logic [31:0] source_address;
    } verdict_rec_t;

    // Recipe for one packet on the wire
    typedef struct packed {
        logic [7:0]   ver_ihl;     // byte 0: version and header length in words
        logic [7:0]   ttl;
        logic [7:0]   proto;
        logic [31:0]  src;
        logic [31:0]  dst;
        logic [15:0]  tot_len;
        logic         spoil_csum;  // flip the checksum's low bit after computing it
        logic [5:0]   cut;         // header bytes sent before the next packet, 0 sends all
        logic [2:0]   lead_noise;  // unflagged bytes sent ahead of byte 0
        logic [3:0]   tail_len;    // payload bytes after the header
        logic         typed;       // use the verdict written below instead of the predictor
        verdict_rec_t want;
    } pkt_spec_t;

    // Directed packets: one row per packet, walked in order.
    // Verdicts are typed in only where they follow at a glance from the row.
    localparam pkt_spec_t DIRECTED [16] = '{
        // clean packet behind stray bytes that arrive with no header open
        '{8'h45, 8'd64,  8'd6,  PEER,  DIR_OWN, 16'd24,    1'b0, 6'd0,  3'd3, 4'd4, 1'b0, '0},
        // wrong version, zero length nibble
        '{8'h00, 8'd0,   8'd0,  32'd0, 32'd0,   16'd0,     1'b0, 6'd0,  3'd0, 4'd2, 1'b1,
          '{ipv4hv_pkg::VERDICT_BAD_VERSION, 6'd0, 16'd0, 32'd0}},
        '{8'hF5, 8'd0,   8'd0,  32'd0, 32'd0,   16'd0,     1'b0, 6'd0,  3'd0, 4'd0, 1'b1,
          '{ipv4hv_pkg::VERDICT_BAD_VERSION, 6'd20, 16'd0, 32'd0}},
        // header length below five words, then a wrong version with the longest length
        '{8'h40, 8'd0,   8'd0,  32'd0, 32'd0,   16'd0,     1'b0, 6'd0,  3'd0, 4'd1, 1'b1,
          '{ipv4hv_pkg::VERDICT_SHORT_HDR, 6'd0, 16'd0, 32'd0}},
        '{8'h44, 8'd0,   8'd0,  32'd0, 32'd0,   16'd0,     1'b0, 6'd0,  3'd0, 4'd0, 1'b1,
          '{ipv4hv_pkg::VERDICT_SHORT_HDR, 6'd16, 16'd0, 32'd0}},
        '{8'h3F, 8'd0,   8'd0,  32'd0, 32'd0,   16'd0,     1'b0, 6'd0,  3'd0, 4'd0, 1'b1,
          '{ipv4hv_pkg::VERDICT_BAD_VERSION, 6'd60, 16'd0, 32'd0}},
        // expired TTL, then one defect each in the order the verdicts are checked
        '{8'h45, 8'd0,   8'd6,  PEER,  DIR_OWN, 16'd40,    1'b0, 6'd0,  3'd0, 4'd0, 1'b1,
          '{ipv4hv_pkg::VERDICT_TTL_ZERO, 6'd20, 16'd40, PEER}},
        '{8'h45, 8'd1,   8'd6,  PEER,  DIR_OWN, 16'd20,    1'b1, 6'd0,  3'd0, 4'd0, 1'b0, '0},
        '{8'h45, 8'd64,  8'd6,  DIR_OWN, DIR_OWN, 16'd20,  1'b0, 6'd0,  3'd0, 4'd0, 1'b0, '0},
        '{8'h45, 8'd64,  8'd6,  PEER,  PEER,    16'd20,    1'b0, 6'd0,  3'd0, 4'd0, 1'b0, '0},
        '{8'h45, 8'd64,  8'd17, PEER,  DIR_OWN, 16'd20,    1'b0, 6'd0,  3'd0, 4'd0, 1'b0, '0},
        // longest header, all-ones fields
        '{8'h4F, 8'hFF,  8'd6,  32'hFFFF_FFFF, DIR_OWN, 16'hFFFF, 1'b0, 6'd0, 3'd0, 4'd0, 1'b0,
          '0},
        // new packet starts mid header, then one byte short of the end
        '{8'h46, 8'd64,  8'd6,  PEER,  DIR_OWN, 16'd30,    1'b0, 6'd10, 3'd0, 4'd0, 1'b0, '0},
        '{8'h45, 8'd64,  8'd6,  PEER,  DIR_OWN, 16'd30,    1'b0, 6'd19, 3'd0, 4'd0, 1'b0, '0},
        '{8'h45, 8'd128, 8'd6,  32'd0, DIR_OWN, 16'd0,     1'b0, 6'd0,  3'd0, 4'd6, 1'b0, '0},
        '{8'h4F, 8'd9,   8'd6,  PEER,  DIR_OWN, 16'd100,   1'b1, 6'd0,  3'd0, 4'd3, 1'b0, '0}
    };

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ipv4hv_pkg::PADDR_WIDTH-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    ipv4hv_pkt_if pkt_ch ();
    ipv4hv_res_if res_ch ();

    ipv4_header_validate_filter DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .pkt     (pkt_ch.sink),
        .res     (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor copy of the registers and the packet state
    logic [31:0] own_addr;
    logic [7:0]  acc_proto;
    logic [5:0]  hdr_pos;
    logic        hdr_open;
    logic [15:0] csum_acc;
    logic [7:0]  high_byte;
    logic [7:0]  vl_byte;
    logic [7:0]  ttl_seen;
    logic [7:0]  proto_seen;
    logic [15:0] tlen_seen;
    logic [31:0] src_seen;
    logic [31:0] dst_seen;

    verdict_rec_t verdicts_due [$];
    bit           typed_armed;
    verdict_rec_t typed_verdict;

    int cycle_count;
    int mismatches;
    int verdicts_seen;
    int bytes_sent;
    int gap_pct;
    int stall_pct;
    int hold_asks;

    // Clock: 4 ns period
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Advance the predictor by one accepted byte; return 1 when it yields a verdict.
    function automatic bit step_header(input logic [7:0] b, input logic first,
                                       output verdict_rec_t r);
        logic [16:0] wide;
        r = '0;
        if (first)
        begin
            // a flagged byte always drops whatever packet was open
            hdr_pos    = 6'd0;
            hdr_open   = 1'b0;
            csum_acc   = 16'd0;
            high_byte  = 8'd0;
            vl_byte    = b;
            ttl_seen   = 8'd0;
            proto_seen = 8'd0;
            tlen_seen  = 16'd0;
            src_seen   = 32'd0;
            dst_seen   = 32'd0;
            r.header_bytes = {b[3:0], 2'b00};
            if (b[7:4] != ipv4hv_pkg::IPV4_VERSION)
            begin
                r.verdict = ipv4hv_pkg::VERDICT_BAD_VERSION;
                return 1'b1;
            end
            if (b[3:0] < ipv4hv_pkg::MIN_IHL_WORDS)
            begin
                r.verdict = ipv4hv_pkg::VERDICT_SHORT_HDR;
                return 1'b1;
            end
            hdr_open  = 1'b1;
            high_byte = b;
            hdr_pos   = 6'd1;
            return 1'b0;
        end
        if (!hdr_open)
            return 1'b0;

        // even positions hold the high half of a word, odd ones complete it
        if (!hdr_pos[0])
            high_byte = b;
        else
        begin
            wide     = {1'b0, csum_acc} + {1'b0, high_byte, b};
            csum_acc = wide[15:0] + {15'd0, wide[16]};
        end
        case (hdr_pos)
            6'd2, 6'd3:                 tlen_seen  = {tlen_seen[7:0], b};
            6'd8:                       ttl_seen   = b;
            6'd9:                       proto_seen = b;
            6'd12, 6'd13, 6'd14, 6'd15: src_seen   = {src_seen[23:0], b};
            6'd16, 6'd17, 6'd18, 6'd19: dst_seen   = {dst_seen[23:0], b};
            default: ;
        endcase
        hdr_pos = hdr_pos + 6'd1;
        if (hdr_pos != {vl_byte[3:0], 2'b00})
            return 1'b0;

        hdr_open         = 1'b0;
        r.header_bytes   = hdr_pos;
        r.total_length   = tlen_seen;
        r.source_address = src_seen;
        if (ttl_seen == 8'd0)
            r.verdict = ipv4hv_pkg::VERDICT_TTL_ZERO;
        else if (csum_acc != ipv4hv_pkg::CSUM_GOOD)
            r.verdict = ipv4hv_pkg::VERDICT_BAD_CSUM;
        else if (src_seen == own_addr)
            r.verdict = ipv4hv_pkg::VERDICT_FROM_SELF;
        else if (dst_seen != own_addr)
            r.verdict = ipv4hv_pkg::VERDICT_NOT_FOR_US;
        else if (proto_seen != acc_proto)
            r.verdict = ipv4hv_pkg::VERDICT_OTHER_PROTO;
        else
            r.verdict = ipv4hv_pkg::VERDICT_ACCEPT;
        return 1'b1;
    endfunction

    // Random packet, well formed or with a single defect
    function automatic pkt_spec_t roll_packet();
        pkt_spec_t  s;
        int         pick;
        logic [3:0] ver;
        s    = '0;
        pick = $urandom_range(99);
        s.ver_ihl  = {ipv4hv_pkg::IPV4_VERSION,
                      ($urandom_range(3) == 0) ? 4'($urandom_range(15, 6))
                                               : ipv4hv_pkg::MIN_IHL_WORDS};
        s.ttl      = 8'($urandom_range(255, 1));
        s.proto    = acc_proto;
        s.src      = $urandom;
        if (s.src == own_addr)
            s.src = ~s.src;
        s.dst      = own_addr;
        s.tot_len  = 16'($urandom_range(16'hFFFF));
        s.tail_len = 4'($urandom_range(6));
        if (pick < 8)
        begin
            ver = 4'($urandom_range(15));
            if (ver == ipv4hv_pkg::IPV4_VERSION)
                ver = 4'hF;
            s.ver_ihl = {ver, 4'($urandom_range(15))};
        end
        else if (pick < 14)
            s.ver_ihl[3:0] = 4'($urandom_range(4));
        else if (pick < 20)
            s.ttl = 8'd0;
        else if (pick < 30)
            s.spoil_csum = 1'b1;
        else if (pick < 36)
            s.src = own_addr;
        else if (pick < 44)
            s.dst = $urandom;
        else if (pick < 52)
            s.proto = 8'($urandom_range(255));
        else if (pick < 58)
            s.cut = 6'($urandom_range(4 * int'(s.ver_ihl[3:0]) - 1, 1));
        else if (pick < 62)
            s.lead_noise = 3'($urandom_range(4, 1));
        return s;
    endfunction

    // All stimulus tasks start and end at a falling edge.

    // Offer one byte, idling first at random, and hold it until the transfer.
    task automatic push_byte(input logic [7:0] b, input logic first);
        while ($urandom_range(99) < gap_pct)
        begin
            pkt_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pkt_ch.valid      <= 1'b1;
        pkt_ch.data_byte  <= b;
        pkt_ch.first_byte <= first;
        @(posedge clk);
        while (!pkt_ch.ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Lay out the header, fill in its checksum and put the packet on the wire.
    task automatic send_packet(input pkt_spec_t s);
        logic [7:0]  hdr [60];
        logic [15:0] sum;
        logic [16:0] wide;
        int          hlen;
        int          span;
        int          n;
        typed_armed   = s.typed;
        typed_verdict = s.want;
        hlen = 4 * int'(s.ver_ihl[3:0]);
        for (n = 0; n < 60; n++)
            hdr[n] = 8'($urandom_range(255));
        hdr[0]                            = s.ver_ihl;
        {hdr[2], hdr[3]}                  = s.tot_len;
        hdr[8]                            = s.ttl;
        hdr[9]                            = s.proto;
        {hdr[10], hdr[11]}                = 16'h0000;
        {hdr[12], hdr[13], hdr[14], hdr[15]} = s.src;
        {hdr[16], hdr[17], hdr[18], hdr[19]} = s.dst;
        sum = 16'h0000;
        for (n = 0; n + 1 < hlen; n += 2)
        begin
            wide = {1'b0, sum} + {1'b0, hdr[n], hdr[n+1]};
            sum  = wide[15:0] + {15'd0, wide[16]};
        end
        {hdr[10], hdr[11]} = ~sum ^ {15'd0, s.spoil_csum};

        // a rejected byte 0 ends the header at once
        if (s.ver_ihl[7:4] != ipv4hv_pkg::IPV4_VERSION
            || s.ver_ihl[3:0] < ipv4hv_pkg::MIN_IHL_WORDS)
            span = 1;
        else if (s.cut != 6'd0)
            span = s.cut;
        else
            span = hlen;

        repeat (s.lead_noise)
            push_byte(8'($urandom_range(255)), 1'b0);
        for (n = 0; n < span; n++)
            push_byte(hdr[n], n == 0);
        if (s.cut == 6'd0)
            repeat (s.tail_len)
                push_byte(8'($urandom_range(255)), 1'b0);
    endtask

    // Register write: setup, then access until pready, then back to idle.
    task automatic reg_write(input ipv4hv_pkg::reg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == ipv4hv_pkg::REG_OWN_ADDRESS)
            own_addr = value;
        else
            acc_proto = value[7:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Drop valid, wait for every verdict owed, then let payload bytes drain.
    task automatic settle();
        pkt_ch.valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_GAP)
            @(negedge clk);
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is asked for.
    initial
    begin : receiver
        int hold_left;
        int hold_served;
        hold_left    = 0;
        hold_served  = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asks != hold_served)
            begin
                hold_served = hold_asks;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Predict at every byte transfer. Typed rows replace the prediction with their own.
    always @(posedge clk)
    begin : byte_watch
        verdict_rec_t fresh;
        if (rst_n && pkt_ch.valid && pkt_ch.ready)
            if (step_header(pkt_ch.data_byte, pkt_ch.first_byte, fresh))
                verdicts_due.push_back(typed_armed ? typed_verdict : fresh);
    end

    // Compare every verdict transfer against the oldest one owed.
    always @(posedge clk)
    begin : verdict_check
        verdict_rec_t seen;
        verdict_rec_t owed;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            seen = '{ipv4hv_pkg::verdict_t'(res_ch.verdict), res_ch.header_bytes,
                     res_ch.total_length, res_ch.source_address};
            verdicts_seen++;
            if (verdicts_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected verdict %0d hdr %0d len %0d src %h", $time,
                         seen.verdict, seen.header_bytes, seen.total_length,
                         seen.source_address);
            end
            else
            begin
                owed = verdicts_due.pop_front();
                if (seen.verdict !== owed.verdict || seen.header_bytes !== owed.header_bytes ||
                    seen.total_length !== owed.total_length ||
                    seen.source_address !== owed.source_address)
                begin
                    mismatches++;
                    $display("%0t: expected verdict %0d hdr %0d len %0d src %h", $time,
                             owed.verdict, owed.header_bytes, owed.total_length,
                             owed.source_address);
                    $display("%0t:   actual verdict %0d hdr %0d len %0d src %h", $time,
                             seen.verdict, seen.header_bytes, seen.total_length,
                             seen.source_address);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : stimulus
        int        phase;
        int        k;
        pkt_spec_t spec;

        // Hold every input at a known value from time zero
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = 32'd0;
        pkt_ch.valid      = 1'b0;
        pkt_ch.data_byte  = 8'd0;
        pkt_ch.first_byte = 1'b0;
        cycle_count       = 0;
        mismatches        = 0;
        verdicts_seen     = 0;
        bytes_sent        = 0;
        gap_pct           = 0;
        stall_pct         = 0;
        hold_asks         = 0;
        typed_armed       = 1'b0;
        typed_verdict     = '0;
        own_addr          = ipv4hv_pkg::OWN_ADDRESS_RESET;
        acc_proto         = ipv4hv_pkg::ACCEPTED_PROTO_RESET;
        hdr_pos           = 6'd0;
        hdr_open          = 1'b0;
        csum_acc          = 16'd0;
        high_byte         = 8'd0;
        vl_byte           = 8'd0;
        ttl_seen          = 8'd0;
        proto_seen        = 8'd0;
        tlen_seen         = 16'd0;
        src_seen          = 32'd0;
        dst_seen          = 32'd0;

        repeat (8)
            @(negedge clk);
        rst_n = 1'b1;

        // Directed packets, no idling on either side
        reg_write(ipv4hv_pkg::REG_OWN_ADDRESS, DIR_OWN);
        reg_write(ipv4hv_pkg::REG_ACCEPTED_PROTOCOL, 32'd6);
        for (k = 0; k < 16; k++)
            send_packet(DIRECTED[k]);
        settle();

        // Random phases: one round, rotating registers and idling
        phase = 0;
        while (phase < 5)
        begin
            case (phase % 5)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                    reg_write(ipv4hv_pkg::REG_OWN_ADDRESS, 32'd0);
                    reg_write(ipv4hv_pkg::REG_ACCEPTED_PROTOCOL, 32'd0);
                end
                1:
                begin
                    gap_pct   = 46;
                    stall_pct = 0;
                    reg_write(ipv4hv_pkg::REG_OWN_ADDRESS, 32'hFFFF_FFFF);
                    reg_write(ipv4hv_pkg::REG_ACCEPTED_PROTOCOL, 32'd255);
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 46;
                    reg_write(ipv4hv_pkg::REG_OWN_ADDRESS, $urandom);
                    reg_write(ipv4hv_pkg::REG_ACCEPTED_PROTOCOL, 32'd17);
                end
                3:
                begin
                    gap_pct   = 15;
                    stall_pct = 15;
                    reg_write(ipv4hv_pkg::REG_OWN_ADDRESS, $urandom);
                    reg_write(ipv4hv_pkg::REG_ACCEPTED_PROTOCOL, 32'($urandom_range(255)));
                end
                default:
                begin
                    // back-pressure: hold the receiver off and keep rejected byte 0s coming
                    // so that the input and result registers fill and the input stalls
                    gap_pct   = 0;
                    stall_pct = 0;
                    reg_write(ipv4hv_pkg::REG_OWN_ADDRESS, $urandom);
                    reg_write(ipv4hv_pkg::REG_ACCEPTED_PROTOCOL, 32'd6);
                    hold_asks++;
                end
            endcase

            for (k = 0; k < ((phase % 5 == 4) ? 40 : 2); k++)
            begin
                spec = roll_packet();
                if (phase % 5 == 4)
                begin
                    spec.ver_ihl    = 8'($urandom_range(63));
                    spec.lead_noise = 3'd0;
                    spec.tail_len   = 4'd0;
                    spec.cut        = 6'd0;
                end
                send_packet(spec);
            end

            // close any header left open so the block is idle before the next writes
            push_byte(8'($urandom_range(63)), 1'b1);
            settle();
            phase++;
        end

        settle();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
